[src/sle_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg
// Shared constants and types of the sorted list engine: capacity, command and
// status codes, and the token that walks along the row of list cells.
// ----------------------------------------------------------------------------
package sle_pkg;

  // list capacity and count width (holds 0 .. CAPACITY)
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // field widths
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 3;
  localparam int COUNT_W  = 5;

  // command codes
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  // status codes
  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_REMOVED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // command token handed from cell to cell, one cell per cycle
  typedef struct packed {
    logic                    act;    // token present
    cmd_t                    op;     // insert or remove
    logic signed [VAL_W-1:0] carry;  // value travelling right
    logic [CNT_W-1:0]        rem;    // entries left from this cell on
    logic                    found;  // remove: match seen, shifting left
    logic                    done;   // end of list reached
  } token_t;

endpackage

[src/sle_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_cell
// One list slot. Holds a stored value and processes the command token when it
// passes: insert swaps in the carried value, remove pulls in the right value.
// ----------------------------------------------------------------------------
module sle_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  sle_pkg::token_t                 tok_in,
  input  logic signed [sle_pkg::VAL_W-1:0] right_value,
  output logic signed [sle_pkg::VAL_W-1:0] value,
  output sle_pkg::token_t                 tok_out
);

  sle_pkg::token_t                  tok_next;
  logic signed [sle_pkg::VAL_W-1:0] value_next;
  logic                             at_end;

  // slot update and outgoing token
  always_comb begin
    at_end     = (tok_in.rem == '0);
    tok_next   = tok_in;
    value_next = value;
    if (!at_end) begin
      tok_next.rem = tok_in.rem - sle_pkg::CNT_W'(1);
    end
    if (tok_in.act && !tok_in.done) begin
      if (at_end) begin
        // first slot past the stored entries
        tok_next.done = 1'b1;
        if (tok_in.op == sle_pkg::CMD_INSERT) begin
          value_next = tok_in.carry;
        end
      end else if (tok_in.op == sle_pkg::CMD_INSERT) begin
        // first not-smaller entry and everything after it move right
        if (value >= tok_in.carry) begin
          value_next     = tok_in.carry;
          tok_next.carry = value;
        end
      end else begin
        // from the first match on, close the gap
        if (tok_in.found || value == tok_in.carry) begin
          tok_next.found = 1'b1;
          value_next     = right_value;
        end
      end
    end
  end

  // token register, control only
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  // stored value, no reset
  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

[src/sle_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_ctrl
// Command front end: keeps the entry count, launches tokens into the cell row,
// collects them at the tail and buffers results for the output channel.
// ----------------------------------------------------------------------------
module sle_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  // command beat
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sle_pkg::cmd_t                     in_cmd,
  input  logic signed [sle_pkg::VAL_W-1:0]  in_value,
  // cell row
  output sle_pkg::token_t                   head_tok,
  input  sle_pkg::token_t                   tail_tok,
  // result beat
  output logic                              out_valid,
  input  logic                              out_ready,
  output sle_pkg::status_t                  out_status,
  output logic [sle_pkg::COUNT_W-1:0]       out_count
);

  logic [sle_pkg::CNT_W-1:0]   cnt;
  logic                        inflight;
  logic                        pend_valid;
  sle_pkg::status_t            pend_status;
  logic [sle_pkg::CNT_W-1:0]   pend_cnt;
  logic                        accept;
  logic                        is_full;
  logic                        is_empty;
  logic                        refuse;     // full insert or empty remove
  logic                        pend_take;  // output register loads pending result
  sle_pkg::token_t             head_next;

  assign in_ready  = !inflight && !pend_valid;
  assign accept    = in_valid && in_ready;
  assign is_full   = (cnt == sle_pkg::CNT_W'(sle_pkg::CAPACITY));
  assign is_empty  = (cnt == '0);
  assign refuse    = accept && ((in_cmd == sle_pkg::CMD_INSERT && is_full) ||
                                (in_cmd == sle_pkg::CMD_REMOVE && is_empty));
  assign pend_take = pend_valid && (!out_valid || out_ready);

  // token launched into the row
  always_comb begin
    head_next = '0;
    if (accept && !refuse) begin
      head_next.act   = 1'b1;
      head_next.op    = in_cmd;
      head_next.carry = in_value;
      head_next.rem   = cnt;
    end
  end

  // launch, completion, count and result buffering
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      inflight   <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      head_tok   <= '0;
    end else begin
      head_tok <= head_next;

      // output register takes the pending result when free
      if (pend_take) begin
        out_valid  <= 1'b1;
        out_status <= pend_status;
        out_count  <= sle_pkg::COUNT_W'(pend_cnt);
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // command in flight until its token leaves the last cell
      if (head_next.act) begin
        inflight <= 1'b1;
      end else if (tail_tok.act) begin
        inflight <= 1'b0;
      end

      // pending result: refused command now, others at the tail
      if (refuse) begin
        pend_valid  <= 1'b1;
        pend_status <= is_full ? sle_pkg::ST_FULL : sle_pkg::ST_EMPTY;
        pend_cnt    <= cnt;
      end else if (tail_tok.act) begin
        pend_valid <= 1'b1;
        if (tail_tok.op == sle_pkg::CMD_INSERT) begin
          pend_status <= sle_pkg::ST_INSERTED;
          pend_cnt    <= cnt + sle_pkg::CNT_W'(1);
          cnt         <= cnt + sle_pkg::CNT_W'(1);
        end else if (tail_tok.found) begin
          pend_status <= sle_pkg::ST_REMOVED;
          pend_cnt    <= cnt - sle_pkg::CNT_W'(1);
          cnt         <= cnt - sle_pkg::CNT_W'(1);
        end else begin
          pend_status <= sle_pkg::ST_NOT_FOUND;
          pend_cnt    <= cnt;
        end
      end else if (pend_take) begin
        pend_valid <= 1'b0;
      end
    end
  end

endmodule

[src/sorted_list_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_engine
// Bounded ascending list of signed 32-bit values with insert and remove
// commands, built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                 tuser
//  s_axis   in   value[31:0]           cmd[0]
//  m_axis   out  count[4:0], 0 pad     status[2:0]
//
//  A command beat walks the row of CAPACITY cells one cell per cycle; its
//  result goes from the last cell through a pending buffer to the output
//  register (full insert and empty remove skip the row). One command is in
//  flight at a time: the next beat is taken once its result leaves the buffer.
//  A finished result may wait on m_axis while the next command is taken.
//  rst clears the count and all control; stored values need no reset.
// ----------------------------------------------------------------------------
module sorted_list_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value[31:0]
  input  logic        s_axis_tuser,   // cmd[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // count[4:0], zeros [7:5]
  output logic [2:0]  m_axis_tuser    // status[2:0]
);

  sle_pkg::token_t                  tok  [sle_pkg::CAPACITY+1];
  logic signed [sle_pkg::VAL_W-1:0] vals [sle_pkg::CAPACITY];
  sle_pkg::status_t                 status;
  logic [sle_pkg::COUNT_W-1:0]      count;

  // command front end
  sle_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_cmd     (sle_pkg::cmd_t'(s_axis_tuser)),
    .in_value   ($signed(s_axis_tdata)),
    .head_tok   (tok[0]),
    .tail_tok   (tok[sle_pkg::CAPACITY]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (status),
    .out_count  (count)
  );

  // row of list cells
  for (genvar i = 0; i < sle_pkg::CAPACITY; i++) begin : g_cell
    logic signed [sle_pkg::VAL_W-1:0] right;
    if (i == sle_pkg::CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid
      assign right = vals[i+1];
    end
    sle_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .tok_in      (tok[i]),
      .right_value (right),
      .value       (vals[i]),
      .tok_out     (tok[i+1])
    );
  end

  assign m_axis_tdata = {3'b000, count};
  assign m_axis_tuser = status;

endmodule
